// ===== sv/bpl_pkg.sv =====
// ----------------------------------------------------------------------------
// bpl_pkg: shared types and codes of the bounded positional list
// action codes, status codes and the beat payloads of both channels
// ----------------------------------------------------------------------------
package bpl_pkg;

	// action codes
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_LIST   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic [4:0]         position;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] item;
		logic [4:0]         item_position;
		logic [4:0]         entries_now;
		logic               last;
	} rsp_t;

endpackage

// ===== sv/bpl_store.sv =====
// ----------------------------------------------------------------------------
// bpl_store: entry memory
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module bpl_store #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [31:0]                wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [31:0]                rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/bpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpl_ctrl: list sequencer
// decodes a command, walks the memory one entry per step and builds results
// ----------------------------------------------------------------------------
module bpl_ctrl #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  bpl_pkg::cmd_t              cmd,
	input  logic                       room,
	output logic                       push,
	output bpl_pkg::rsp_t              res,
	output logic                       mem_we,
	output logic [$clog2(DEPTH)-1:0]   mem_waddr,
	output logic [31:0]                mem_wdata,
	output logic                       mem_re,
	output logic [$clog2(DEPTH)-1:0]   mem_raddr,
	input  logic [31:0]                mem_rdata
);
	import bpl_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = ((CW > 5) ? CW : 5) + 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RES    = 3'd1;
	localparam logic [2:0] S_INS    = 3'd2;
	localparam logic [2:0] S_INS_WR = 3'd3;
	localparam logic [2:0] S_RM_CAP = 3'd4;
	localparam logic [2:0] S_RM     = 3'd5;
	localparam logic [2:0] S_RM_WR  = 3'd6;
	localparam logic [2:0] S_LIST   = 3'd7;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] posm1_q;
	logic [31:0]   val_q;
	logic [31:0]   removed_q;
	rsp_t          res_q;

	logic          accept;
	logic [WW-1:0] pos_w;
	logic [WW-1:0] cnt_w;
	logic [WW-1:0] posm1_w;
	logic          ins_bad;
	logic          rm_bad;
	logic          is_full;
	logic          is_empty;
	logic          list_last;
	logic [CW-1:0] idx_inc;
	logic [CW-1:0] idx_dec;

	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign cmd_stall = (state_q != S_IDLE);

	assign pos_w    = WW'(cmd.position);
	assign cnt_w    = WW'(count_q);
	assign posm1_w  = pos_w - WW'(1);
	assign ins_bad  = (pos_w == '0) || (pos_w > cnt_w + WW'(1));
	assign rm_bad   = (pos_w == '0) || (pos_w > cnt_w);
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	assign idx_inc   = idx_q + CW'(1);
	assign idx_dec   = idx_q - CW'(1);
	assign list_last = (idx_inc == count_q);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[IW-1:0];
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = idx_q[IW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (accept && cmd.action == ACT_REMOVE && !is_empty && !rm_bad) begin
					mem_re    = 1'b1;
					mem_raddr = posm1_w[IW-1:0];
				end else if (accept && cmd.action == ACT_LIST && !is_empty) begin
					mem_re    = 1'b1;
					mem_raddr = '0;
				end
			end
			S_INS: begin
				if (idx_q == posm1_q) begin
					mem_we    = 1'b1;
					mem_wdata = val_q;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_dec[IW-1:0];
				end
			end
			S_INS_WR: begin
				mem_we = 1'b1;
			end
			S_RM: begin
				mem_re = (idx_q != count_q);
			end
			S_RM_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_dec[IW-1:0];
			end
			S_LIST: begin
				if (room && !list_last) begin
					mem_re    = 1'b1;
					mem_raddr = idx_inc[IW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// result out of the sequencer
	always_comb begin
		res  = res_q;
		push = 1'b0;
		unique case (state_q)
			S_RES: begin
				push = room;
			end
			S_LIST: begin
				push              = room;
				res.status        = ST_OK;
				res.item          = mem_rdata;
				res.item_position = 5'(idx_inc);
				res.entries_now   = 5'(count_q);
				res.last          = list_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (cmd.action)
							ACT_INSERT: begin
								if (!is_full && !ins_bad) begin
									state_q <= S_INS;
								end else begin
									state_q <= S_RES;
								end
							end
							ACT_REMOVE: begin
								if (!is_empty && !rm_bad) begin
									state_q <= S_RM_CAP;
								end else begin
									state_q <= S_RES;
								end
							end
							ACT_LIST: begin
								if (!is_empty) begin
									state_q <= S_LIST;
								end else begin
									state_q <= S_RES;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RES: begin
					if (room) begin
						state_q <= S_IDLE;
					end
				end
				S_INS: begin
					if (idx_q == posm1_q) begin
						count_q <= count_q + CW'(1);
						state_q <= S_RES;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					state_q <= S_INS;
				end
				S_RM_CAP: begin
					state_q <= S_RM;
				end
				S_RM: begin
					if (idx_q == count_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_RES;
					end else begin
						state_q <= S_RM_WR;
					end
				end
				S_RM_WR: begin
					state_q <= S_RM;
				end
				S_LIST: begin
					if (room && list_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q   <= cmd.value;
					posm1_q <= CW'(posm1_w);
					res_q.item          <= '0;
					res_q.item_position <= '0;
					res_q.entries_now   <= 5'(count_q);
					res_q.last          <= 1'b1;
					if (cmd.action == ACT_INSERT) begin
						idx_q <= count_q;
						if (is_full) begin
							res_q.status <= ST_FULL;
						end else begin
							res_q.status <= ins_bad ? ST_BADPOS : ST_OK;
						end
					end else begin
						idx_q <= '0;
						if (is_empty) begin
							res_q.status <= ST_EMPTY;
						end else begin
							res_q.status <= rm_bad ? ST_BADPOS : ST_OK;
						end
					end
				end
			end
			S_INS: begin
				if (idx_q == posm1_q) begin
					res_q.item          <= val_q;
					res_q.item_position <= 5'(posm1_q + CW'(1));
					res_q.entries_now   <= 5'(count_q + CW'(1));
				end
			end
			S_INS_WR: begin
				idx_q <= idx_dec;
			end
			S_RM_CAP: begin
				removed_q <= mem_rdata;
				idx_q     <= posm1_q + CW'(1);
			end
			S_RM: begin
				if (idx_q == count_q) begin
					res_q.item          <= removed_q;
					res_q.item_position <= 5'(posm1_q + CW'(1));
					res_q.entries_now   <= 5'(count_q - CW'(1));
				end
			end
			S_RM_WR: begin
				idx_q <= idx_inc;
			end
			S_LIST: begin
				if (room) begin
					idx_q <= idx_inc;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/bounded_positional_list.sv =====
// ----------------------------------------------------------------------------
// bounded_positional_list: ordered list with insert and remove by position
// up to DEPTH signed words, 1-based positions, listing of all entries
//
//   channel | direction | beat  | handshake
//   cmd     | in        | cmd_t | cmd_valid / cmd_stall
//   rsp     | out       | rsp_t | rsp_valid / rsp_stall
//
// one command at a time; an unused action is dropped with no beat and an
// error goes straight to its result; insert and remove shift the entries
// from the position on, each shifted entry read and then written back through
// the single memory port pair; a list gives one beat per cycle while rsp is
// not stalled
// reset clears the count and control; memory contents need no clearing
// a stalled rsp holds its beat, and a new command is taken while it waits;
// the next result then waits in the sequencer until the output register frees
// ----------------------------------------------------------------------------
module bounded_positional_list #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  bpl_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bpl_pkg::rsp_t rsp
);
	import bpl_pkg::*;

	localparam int IW = $clog2(DEPTH);

	// memory port between sequencer and store
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;

	// result path into the output register
	logic room;
	logic push;
	rsp_t res;

	logic rsp_valid_q;
	rsp_t rsp_q;

	// the output register can load when empty or when its beat leaves now
	assign room = !rsp_valid_q || !rsp_stall;

	bpl_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.room      (room),
		.push      (push),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bpl_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (room) begin
			rsp_valid_q <= push;
		end
	end

	// output register: beat payload, held while stalled
	always_ff @(posedge clk) begin
		if (room && push) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== test/bounded_positional_list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_positional_list_checker: result scoreboard for the positional list
// keeps its own copy of the list, works out the result beats of every
// accepted command and matches them in order against the result channel
// ----------------------------------------------------------------------------
module bounded_positional_list_checker #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_stall,
	input  bpl_pkg::cmd_t cmd,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  bpl_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending,
	output int            beats_checked,
	output int            full_seen
);
	import bpl_pkg::*;

	logic signed [31:0] held [DEPTH];
	int                 fill;
	rsp_t               expected_beats [$];
	rsp_t               want;
	int                 mismatches = 0;
	int                 beats = 0;
	int                 fulls = 0;

	function automatic rsp_t make_beat(input logic [1:0] st, input logic signed [31:0] val,
			input int p, input int n, input logic fin);
		rsp_t r;
		r.status        = st;
		r.item          = val;
		r.item_position = p[4:0];
		r.entries_now   = n[4:0];
		r.last          = fin;
		return r;
	endfunction

	// updates the list copy and queues the beats one command gives
	task automatic apply_list_command(input cmd_t c);
		int p;
		int i;
		p = int'(c.position);
		case (c.action)
			ACT_INSERT: begin
				// full wins over a bad position
				if (fill >= DEPTH) begin
					expected_beats.push_back(make_beat(ST_FULL, 0, 0, fill, 1'b1));
				end else if (p < 1 || p > fill + 1) begin
					expected_beats.push_back(make_beat(ST_BADPOS, 0, 0, fill, 1'b1));
				end else begin
					for (i = fill; i >= p; i--)
						held[i] = held[i - 1];
					held[p - 1] = c.value;
					fill++;
					expected_beats.push_back(make_beat(ST_OK, c.value, p, fill, 1'b1));
				end
			end
			ACT_REMOVE: begin
				// empty wins over a bad position
				if (fill == 0) begin
					expected_beats.push_back(make_beat(ST_EMPTY, 0, 0, 0, 1'b1));
				end else if (p < 1 || p > fill) begin
					expected_beats.push_back(make_beat(ST_BADPOS, 0, 0, fill, 1'b1));
				end else begin
					expected_beats.push_back(make_beat(ST_OK, held[p - 1], p, fill - 1, 1'b1));
					for (i = p; i < fill; i++)
						held[i - 1] = held[i];
					fill--;
				end
			end
			ACT_LIST: begin
				if (fill == 0) begin
					expected_beats.push_back(make_beat(ST_EMPTY, 0, 0, 0, 1'b1));
				end else begin
					for (i = 0; i < fill; i++)
						expected_beats.push_back(make_beat(ST_OK, held[i], i + 1, fill,
							i == fill - 1));
				end
			end
			default: ;  // unused code: no beat, list untouched
		endcase
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want_val);
		if (got !== want_val)
			report_mismatch($sformatf("result beat %0d: %s is %0h, should be %0h",
				beats, name, got, want_val));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			expected_beats.delete();
		end else begin
			// match the result beat first: it can only belong to an older command
			if (rsp_valid && !rsp_stall) begin
				if (expected_beats.size() == 0) begin
					report_mismatch($sformatf("result beat %0d arrived with none outstanding",
						beats));
				end else begin
					want = expected_beats.pop_front();
					check_field("status", rsp.status, want.status);
					check_field("item", rsp.item, want.item);
					check_field("item_position", rsp.item_position, want.item_position);
					check_field("entries_now", rsp.entries_now, want.entries_now);
					check_field("last", rsp.last, want.last);
					if (want.status == ST_FULL)
						fulls++;
				end
				beats++;
			end
			if (cmd_valid && !cmd_stall)
				apply_list_command(cmd);
		end
		fail_count    <= mismatches;
		pending       <= expected_beats.size();
		beats_checked <= beats;
		full_seen     <= fulls;
	end

endmodule

// ===== test/bounded_positional_list_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_positional_list_test: testbench top of the bounded positional list
// drives a directed run over empty, bad-position and edge-value cases, then
// random insert/remove/list traffic in grow and shrink stretches under three
// idle patterns; a checker beside the block predicts and compares every beat
// ----------------------------------------------------------------------------
module bounded_positional_list_test;
	import bpl_pkg::*;

	localparam int         DEPTH        = 16;
	localparam int         PERIOD       = 10;
	localparam int         RANDOM_ITEMS = 500;
	// cycles with no beat on either channel before the run is declared hung
	localparam int         QUIET_LIMIT  = 4000;
	// an insert at position 1 of a nearly full list shifts nearly every entry
	localparam int         TAIL_CYCLES  = 2 * DEPTH + 8;
	// action code the block must ignore
	localparam logic [1:0] ACT_UNUSED   = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// idle rates of both sides, in percent of cycles
	int send_idle_pct = 0;
	int stall_pct = 0;

	// fill level as the stimulus sees it, only used to aim positions
	int shadow_fill = 0;
	int inserts_sent = 0;
	int removes_sent = 0;
	int lists_sent = 0;
	int unused_sent = 0;
	int quiet = 0;

	int fail_count;
	int pending;
	int beats_checked;
	int full_seen;

	always #(PERIOD / 2) clk = ~clk;

	bounded_positional_list #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	bounded_positional_list_checker #(
		.DEPTH(DEPTH)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending),
		.beats_checked(beats_checked),
		.full_seen(full_seen)
	);

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		if (!arst_n)
			rsp_stall <= 1'b0;
		else
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// watchdog: ends the run when no beat moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
				quiet <= 0;
			end else if (quiet + 1 >= QUIET_LIMIT) begin
				$display("no beat moved for %0d cycles", QUIET_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// one command beat: optional idle gap, then hold valid until taken
	task automatic send_command(input logic [1:0] act, input int pos,
			input logic signed [31:0] val);
		cmd_t next_cmd;
		next_cmd.action   = act;
		next_cmd.position = pos[4:0];
		next_cmd.value    = val;
		// valid only drops when a gap follows, never for a back-to-back beat
		if ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		cmd       <= next_cmd;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		// track the fill level so random positions land mostly in range
		case (act)
			ACT_INSERT: begin
				inserts_sent++;
				if (shadow_fill < DEPTH && pos >= 1 && pos <= shadow_fill + 1)
					shadow_fill++;
			end
			ACT_REMOVE: begin
				removes_sent++;
				if (shadow_fill > 0 && pos >= 1 && pos <= shadow_fill)
					shadow_fill--;
			end
			ACT_LIST: lists_sent++;
			default:  unused_sent++;
		endcase
	endtask

	initial begin
		int                 ph;
		int                 n;
		int                 roll;
		int                 pos;
		bit                 grow;
		logic [1:0]         act;
		logic signed [31:0] val;

		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, under a slow receiver
		send_idle_pct = 17;
		stall_pct     = 77;
		// empty list: list, and remove where empty beats a bad position
		send_command(ACT_LIST, 0, 32'sd0);
		send_command(ACT_REMOVE, 0, 32'sd0);
		send_command(ACT_REMOVE, 31, 32'sd0);
		// position zero and a position past count+1 are both rejected
		send_command(ACT_INSERT, 0, 32'sd5);
		send_command(ACT_INSERT, 2, 32'sd5);
		// extreme values at the front, the back and in between
		send_command(ACT_INSERT, 1, 32'sh8000_0000);
		send_command(ACT_INSERT, 2, 32'sh7fff_ffff);
		send_command(ACT_INSERT, 1, -32'sd1);
		send_command(ACT_INSERT, 4, 32'sd0);
		// unused action code: no beat and no change
		send_command(ACT_UNUSED, 3, 32'sh5555_aaaa);
		send_command(ACT_LIST, 17, 32'sd0);
		// remove: position zero, one past the end, middle, tail
		send_command(ACT_REMOVE, 0, 32'sd0);
		send_command(ACT_REMOVE, 5, 32'sd0);
		send_command(ACT_REMOVE, 2, 32'sd0);
		send_command(ACT_REMOVE, 3, 32'sd0);
		send_command(ACT_LIST, 0, 32'sd0);

		// random part: slow receiver, then slow sender, then full speed
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 17;
					stall_pct     = 77;
				end
				1: begin
					send_idle_pct = 77;
					stall_pct     = 17;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
			endcase
			n    = 0;
			grow = 1'b1;
			while (n < RANDOM_ITEMS / 3) begin
				// stretches that favor inserts drive the list to full,
				// the others drain it to empty
				if (n % 32 == 0)
					grow = 1'($urandom_range(0, 1));
				val = $urandom;
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 3))
						0:       val = 32'sh8000_0000;
						1:       val = 32'sh7fff_ffff;
						2:       val = 32'sd0;
						default: val = -32'sd1;
					endcase
				end
				roll = $urandom_range(0, 99);
				// a few unused codes as noise, not counted as items
				if (roll < 3) begin
					send_command(ACT_UNUSED, $urandom_range(0, 31), val);
					continue;
				end
				if (roll < 13)
					act = ACT_LIST;
				else if ($urandom_range(0, 99) < (grow ? 72 : 28))
					act = ACT_INSERT;
				else
					act = ACT_REMOVE;
				// mostly valid positions, some anywhere in the field
				if ($urandom_range(0, 99) < 15)
					pos = $urandom_range(0, 31);
				else if (act == ACT_INSERT)
					pos = $urandom_range(1, shadow_fill + 1);
				else
					pos = $urandom_range(1, (shadow_fill > 0) ? shadow_fill : 1);
				send_command(act, pos, val);
				n++;
			end
		end
		cmd_valid <= 1'b0;

		// drain: let the checker count the last command, then wait it out
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d commands: %0d insert, %0d remove, %0d list, %0d unused code",
			inserts_sent + removes_sent + lists_sent + unused_sent,
			inserts_sent, removes_sent, lists_sent, unused_sent);
		$display("checked %0d result beats over three idle patterns, %0d full rejections",
			beats_checked, full_seen);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/bpl_pkg.sv
sv/bpl_store.sv
sv/bpl_ctrl.sv
sv/bounded_positional_list.sv
test/bounded_positional_list_checker.sv
test/bounded_positional_list_test.sv
